[design/mer_pkg.sv]
// ----------------------------------------------------------------------------
// mer_pkg
// Shared widths, command codes and control/status structures of the midpoint
// ellipse rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

   // Field widths.
   localparam int AXIS_BITS  = 11;
   localparam int COORD_BITS = 12;
   localparam int OUT_BITS   = COORD_BITS + 2;

   // Internal arithmetic widths.
   localparam int SQ_BITS    = 2 * AXIS_BITS;
   localparam int DEC_BITS   = 4 * AXIS_BITS + 4;
   localparam int MUL_A_BITS = SQ_BITS + AXIS_BITS + 1;
   localparam int MUL_B_BITS = SQ_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Input command codes.
   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   // Operand selection of the shared multiplier.
   typedef enum logic [3:0] {
      MUL_AA,   // a * a
      MUL_BB,   // b * b
      MUL_A2B,  // a^2 * b
      MUL_P1,   // b^2 * (x + 1)
      MUL_P2,   // a^2 * (2y - 1)
      MUL_Q1,   // b^2 * (2x + 1)
      MUL_Q2,   // previous product * (2x + 1)
      MUL_R1,   // a^2 * (y - 1)
      MUL_R2,   // previous product * (y - 1)
      MUL_S     // a^2 * b^2
   } mul_sel_type;

   // Update of the decision register.
   typedef enum logic [2:0] {
      DEC_HOLD,
      DEC_INIT,
      DEC_SWITCH,
      DEC_UPD1,
      DEC_UPD2
   } dec_op_type;

   // Update of the side-arc accumulator.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_start;
      mul_sel_type mul_sel;
      logic        load_a2;
      logic        load_b2;
      logic        load_p1;
      logic        load_decide;
      acc_op_type  acc_op;
      dec_op_type  dec_op;
      logic        load_out;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic arc_continues;
      logic y_zero;
   } dp_stat_type;

endpackage

`default_nettype wire

[design/mer_req_if.sv]
// ----------------------------------------------------------------------------
// mer_req_if
// Request channel: a start or step command with the ellipse geometry.
// ----------------------------------------------------------------------------
`default_nettype none

interface mer_req_if import mer_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [COORD_BITS-1:0] center_x;
   logic [COORD_BITS-1:0] center_y;
   logic [AXIS_BITS-1:0]  semi_a;
   logic [AXIS_BITS-1:0]  semi_b;

   modport source (
      output valid, command, center_x, center_y, semi_a, semi_b,
      input  ready
   );

   modport sink (
      input  valid, command, center_x, center_y, semi_a, semi_b,
      output ready
   );

endinterface

`default_nettype wire

[design/mer_rsp_if.sv]
// ----------------------------------------------------------------------------
// mer_rsp_if
// Response channel: one rasterized point mirrored into four quadrants.
// ----------------------------------------------------------------------------
`default_nettype none

interface mer_rsp_if import mer_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] right_x;
   logic signed [OUT_BITS-1:0] left_x;
   logic signed [OUT_BITS-1:0] lower_y;
   logic signed [OUT_BITS-1:0] upper_y;
   logic                       last;

   modport source (
      output valid, right_x, left_x, lower_y, upper_y, last,
      input  ready
   );

   modport sink (
      input  valid, right_x, left_x, lower_y, upper_y, last,
      output ready
   );

endinterface

`default_nettype wire

[design/mer_datapath.sv]
// ----------------------------------------------------------------------------
// mer_datapath
// Geometry registers, shared multiplier, decision arithmetic and the output
// register of the ellipse rasterizer. Sequenced by mer_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_datapath import mer_pkg::*; (
   input  logic                       clock,
   input  logic [COORD_BITS-1:0]      req_center_x,
   input  logic [COORD_BITS-1:0]      req_center_y,
   input  logic [AXIS_BITS-1:0]       req_semi_a,
   input  logic [AXIS_BITS-1:0]       req_semi_b,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   output logic signed [OUT_BITS-1:0] rsp_right_x,
   output logic signed [OUT_BITS-1:0] rsp_left_x,
   output logic signed [OUT_BITS-1:0] rsp_lower_y,
   output logic signed [OUT_BITS-1:0] rsp_upper_y,
   output logic                       rsp_last
);

   // Geometry and point registers.
   logic [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [AXIS_BITS-1:0]  a_ff;
   logic [AXIS_BITS-1:0]  x_ff, x_in;
   logic [AXIS_BITS-1:0]  y_ff, y_in;
   logic [SQ_BITS-1:0]    a2_ff, b2_ff;

   // Arithmetic registers; all wrap modulo 2^DEC_BITS.
   logic [DEC_BITS-1:0]   prod_ff, prod_in;
   logic [DEC_BITS-1:0]   p1_ff;
   logic [DEC_BITS-1:0]   inc1_ff, sub1_ff, sub2_ff;
   logic [DEC_BITS-1:0]   acc_ff, acc_in;
   logic [DEC_BITS-1:0]   dec_ff, dec_in;

   // Output register.
   logic signed [OUT_BITS-1:0] right_x_ff, left_x_ff, lower_y_ff, upper_y_ff;
   logic                       last_ff;

   // Derived operands.
   logic [AXIS_BITS:0]    x_inc, x_odd, y_odd;
   logic [AXIS_BITS-1:0]  y_dec;
   logic [DEC_BITS-1:0]   a2_ext, b2_ext;
   logic [MUL_A_BITS-1:0] mul_a;
   logic [MUL_B_BITS-1:0] mul_b;
   logic [PROD_BITS-1:0]  mul_full;
   logic                  dec_neg;
   logic                  y_zero;

   assign x_inc   = (AXIS_BITS+1)'(x_ff) + (AXIS_BITS+1)'(1);
   assign x_odd   = {x_ff, 1'b1};
   assign y_odd   = {y_ff, 1'b0} - (AXIS_BITS+1)'(1);
   assign y_dec   = y_ff - AXIS_BITS'(1);
   assign a2_ext  = DEC_BITS'(a2_ff);
   assign b2_ext  = DEC_BITS'(b2_ff);
   assign dec_neg = dec_ff[DEC_BITS-1];
   assign y_zero  = (y_ff == '0);

   // Operand selection of the shared multiplier.
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_AA: begin
            mul_a = MUL_A_BITS'(a_ff);
            mul_b = MUL_B_BITS'(a_ff);
         end
         MUL_BB: begin
            mul_a = MUL_A_BITS'(y_ff);
            mul_b = MUL_B_BITS'(y_ff);
         end
         MUL_A2B: begin
            mul_a = MUL_A_BITS'(a2_ff);
            mul_b = MUL_B_BITS'(y_ff);
         end
         MUL_P1: begin
            mul_a = MUL_A_BITS'(b2_ff);
            mul_b = MUL_B_BITS'(x_inc);
         end
         MUL_P2: begin
            mul_a = MUL_A_BITS'(a2_ff);
            mul_b = MUL_B_BITS'(y_odd);
         end
         MUL_Q1: begin
            mul_a = MUL_A_BITS'(b2_ff);
            mul_b = MUL_B_BITS'(x_odd);
         end
         MUL_Q2: begin
            mul_a = prod_ff[MUL_A_BITS-1:0];
            mul_b = MUL_B_BITS'(x_odd);
         end
         MUL_R1: begin
            mul_a = MUL_A_BITS'(a2_ff);
            mul_b = MUL_B_BITS'(y_dec);
         end
         MUL_R2: begin
            mul_a = prod_ff[MUL_A_BITS-1:0];
            mul_b = MUL_B_BITS'(y_dec);
         end
         MUL_S: begin
            mul_a = MUL_A_BITS'(a2_ff);
            mul_b = b2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // The product is registered before any further use.
   assign mul_full = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   assign prod_in  = mul_full[DEC_BITS-1:0];

   // Side-arc start value is built up from three products.
   always_comb begin
      unique case (cmd.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = acc_ff + (prod_ff << 2);
         default:  acc_in = acc_ff;
      endcase
   end

   // Decision value and point update.
   always_comb begin
      dec_in = dec_ff;
      x_in   = x_ff;
      y_in   = y_ff;
      unique case (cmd.dec_op)
         DEC_HOLD: dec_in = dec_ff;
         DEC_INIT: dec_in = (b2_ext << 2) + a2_ext - (prod_ff << 2);
         DEC_SWITCH: dec_in = acc_ff - (prod_ff << 2);
         DEC_UPD1: begin
            // Upper arc: x always moves, y moves on a non-negative decision.
            dec_in = dec_ff + (inc1_ff << 2) - (dec_neg ? '0 : (sub1_ff << 2));
            x_in   = x_inc[AXIS_BITS-1:0];
            if (!dec_neg) begin
               y_in = y_dec;
            end
         end
         DEC_UPD2: begin
            // Side arc: y always moves, x moves on a negative decision.
            dec_in = dec_ff + (dec_neg ? (p1_ff << 2) : '0) - (sub2_ff << 2);
            y_in   = y_dec;
            if (dec_neg) begin
               x_in = x_inc[AXIS_BITS-1:0];
            end
         end
         default: dec_in = dec_ff;
      endcase
      if (cmd.load_start) begin
         x_in = '0;
         y_in = req_semi_b;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      dec_ff  <= dec_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      if (cmd.load_start) begin
         cx_ff <= req_center_x;
         cy_ff <= req_center_y;
         a_ff  <= req_semi_a;
      end
      if (cmd.load_a2) begin
         a2_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (cmd.load_b2) begin
         b2_ff <= prod_ff[SQ_BITS-1:0];
      end
      if (cmd.load_p1) begin
         p1_ff <= prod_ff << 1;
      end
      if (cmd.load_decide) begin
         inc1_ff <= p1_ff + b2_ext;
         sub1_ff <= prod_ff - a2_ext;
         sub2_ff <= prod_ff - (a2_ext << 1);
      end
      if (cmd.load_out) begin
         right_x_ff <= $signed(OUT_BITS'(cx_ff) + OUT_BITS'(x_ff));
         left_x_ff  <= $signed(OUT_BITS'(cx_ff) - OUT_BITS'(x_ff));
         lower_y_ff <= $signed(OUT_BITS'(cy_ff) + OUT_BITS'(y_ff));
         upper_y_ff <= $signed(OUT_BITS'(cy_ff) - OUT_BITS'(y_ff));
         last_ff    <= y_zero;
      end
   end

   // Upper-arc test: 2b^2(x+1) < a^2(2y-1), with the right side in prod_ff.
   assign stat.arc_continues = !y_zero && (p1_ff < prod_ff);
   assign stat.y_zero        = y_zero;

   assign rsp_right_x = right_x_ff;
   assign rsp_left_x  = left_x_ff;
   assign rsp_lower_y = lower_y_ff;
   assign rsp_upper_y = upper_y_ff;
   assign rsp_last    = last_ff;

endmodule

`default_nettype wire

[design/mer_ctrl.sv]
// ----------------------------------------------------------------------------
// mer_ctrl
// Sequencer of the ellipse rasterizer: accepts commands, steps the datapath
// through its multiply schedule and owns the response valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module mer_ctrl import mer_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_command,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A2,
      ST_B2,
      ST_AB,
      ST_DINIT,
      ST_P1,
      ST_P2,
      ST_DECIDE,
      ST_UPD1,
      ST_SW_Q1,
      ST_SW_Q2,
      ST_SW_R1,
      ST_SW_R2,
      ST_SW_S,
      ST_SW_SUM,
      ST_UPD2,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      active_ff, active_in;
   logic      region_ff, region_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state and datapath commands.
   always_comb begin
      state_in         = state_ff;
      active_in        = active_ff;
      region_in        = region_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      cmd              = '0;
      cmd.mul_sel      = MUL_AA;
      cmd.acc_op       = ACC_HOLD;
      cmd.dec_op       = DEC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_START) begin
                  cmd.load_start = 1'b1;
                  active_in      = 1'b1;
                  region_in      = 1'b0;
                  state_in       = ST_A2;
               end else if (active_ff) begin
                  state_in = ST_P1;
               end
            end
         end
         // Start: square both axes, then form the upper-arc decision.
         ST_A2: begin
            cmd.mul_sel = MUL_AA;
            state_in    = ST_B2;
         end
         ST_B2: begin
            cmd.load_a2 = 1'b1;
            cmd.mul_sel = MUL_BB;
            state_in    = ST_AB;
         end
         ST_AB: begin
            cmd.load_b2 = 1'b1;
            cmd.mul_sel = MUL_A2B;
            state_in    = ST_DINIT;
         end
         ST_DINIT: begin
            cmd.dec_op = DEC_INIT;
            state_in   = ST_EMIT;
         end
         // Step: both arc-test products, then branch.
         ST_P1: begin
            cmd.mul_sel = MUL_P1;
            state_in    = ST_P2;
         end
         ST_P2: begin
            cmd.load_p1 = 1'b1;
            cmd.mul_sel = MUL_P2;
            state_in    = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.load_decide = 1'b1;
            if (!region_ff) begin
               state_in = stat.arc_continues ? ST_UPD1 : ST_SW_Q1;
            end else if (stat.y_zero) begin
               active_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_UPD2;
            end
         end
         ST_UPD1: begin
            cmd.dec_op = DEC_UPD1;
            state_in   = ST_EMIT;
         end
         // Arc switch: b^2(2x+1)^2 + 4a^2(y-1)^2 - 4a^2b^2.
         ST_SW_Q1: begin
            cmd.mul_sel = MUL_Q1;
            state_in    = ST_SW_Q2;
         end
         ST_SW_Q2: begin
            cmd.mul_sel = MUL_Q2;
            state_in    = ST_SW_R1;
         end
         ST_SW_R1: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_R1;
            state_in    = ST_SW_R2;
         end
         ST_SW_R2: begin
            cmd.mul_sel = MUL_R2;
            state_in    = ST_SW_S;
         end
         ST_SW_S: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_sel = MUL_S;
            state_in    = ST_SW_SUM;
         end
         ST_SW_SUM: begin
            cmd.dec_op = DEC_SWITCH;
            region_in  = 1'b1;
            if (stat.y_zero) begin
               active_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               state_in = ST_UPD2;
            end
         end
         ST_UPD2: begin
            cmd.dec_op = DEC_UPD2;
            state_in   = ST_EMIT;
         end
         // Hand the point to the output register once it is free.
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               if (stat.y_zero) begin
                  active_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         region_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         region_ff    <= region_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // The output register is only written when it is empty or being drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("point written over a response beat not yet taken");

   // A new response beat only comes out of the emit state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("response valid raised outside the emit state");

   // A step with no ellipse in progress is consumed without any work.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && req_command == CMD_STEP && !active_ff)
      |=> (state_ff == ST_IDLE))
      else $error("idle step started a computation");

   // The arc switch always leaves the side-arc flag set.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SW_SUM) |=> region_ff)
      else $error("arc switch did not enter the side arc");

endmodule

`default_nettype wire

[design/midpoint_ellipse_rasterizer.sv]
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// Midpoint ellipse rasterizer: at most one quadrant-mirrored point per command.
// ----------------------------------------------------------------------------
// A start beat (command 0) latches the center and semi-axes a, b and returns
// the point (0, b); each step beat (command 1) returns the next point, first
// along the upper arc and then along the side arc, until a point with y = 0
// is returned with last set. A step with no ellipse in progress, or the step
// that finds the side arc already at y = 0, returns nothing; a start always
// abandons the running ellipse. All decision arithmetic is exact integer
// math scaled by four. One shared multiplier with a registered product does
// every multiplication, and its schedule orders the work: a start squares
// both axes and forms the first decision, a regular step forms both arc-test
// products and updates the point, and the step on which the upper arc ends
// takes five more products to seed the side arc. A new beat is taken only
// once the previous one has put its point in the output register or has
// finished without one. A point waits in the output register if the response
// side stalls, while the next request is already accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_ellipse_rasterizer import mer_pkg::*; (
   input  logic  clock,
   input  logic  reset,
   mer_req_if.sink   req_chan,
   mer_rsp_if.source rsp_chan
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Command sequencer.
   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // Arithmetic and output register.
   mer_datapath u_datapath (
      .clock        (clock),
      .req_center_x (req_chan.center_x),
      .req_center_y (req_chan.center_y),
      .req_semi_a   (req_chan.semi_a),
      .req_semi_b   (req_chan.semi_b),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_right_x  (rsp_chan.right_x),
      .rsp_left_x   (rsp_chan.left_x),
      .rsp_lower_y  (rsp_chan.lower_y),
      .rsp_upper_y  (rsp_chan.upper_y),
      .rsp_last     (rsp_chan.last)
   );

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the midpoint ellipse rasterizer.
// ----------------------------------------------------------------------------
// Start and step beats go in on the request channel. Each accepted beat is
// fed to a cycle-free model of the midpoint ellipse scheme, which queues the
// point it yields. Each returned point is checked against the oldest queued
// one. Both channels stall at random. There is also a stretch with no
// stalls at all, a long response hold-off that backs up the request side,
// and a pause of the sender until every point has been returned.
// ----------------------------------------------------------------------------

module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mer_pkg::*;

   localparam int unsigned ITEM_TARGET  = 1450;
   localparam int unsigned LIMIT_CYCLES = 600000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned TAIL_CYCLES  = 40;
   localparam int unsigned IDLE_PCT     = 26;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] right_x;
      logic signed [OUT_BITS-1:0] left_x;
      logic signed [OUT_BITS-1:0] lower_y;
      logic signed [OUT_BITS-1:0] upper_y;
      logic                       last;
   } plot_point_type;

   typedef enum int {
      PH_CORNER,
      PH_STEADY,
      PH_BACKLOG,
      PH_RANDOM,
      PH_DRAIN
   } phase_type;

   // Tracks the ellipse walk and holds the points still to be returned.
   class ellipse_scoreboard;
      bit [31:0]           walk_x;
      bit [31:0]           walk_y;
      bit [63:0]           decision;
      bit                  on_side_arc;
      bit                  drawing;
      bit [COORD_BITS-1:0] hold_cx;
      bit [COORD_BITS-1:0] hold_cy;
      bit [63:0]           a_sq;
      bit [63:0]           b_sq;
      plot_point_type      expected_points[$];
      int unsigned         errors;
      int unsigned         requests_noted;

      function void flag_error(string what);
         errors++;
         if (errors <= 10) begin
            $display("%s", what);
         end
      endfunction

      // Mirror the current point into the four quadrants and queue it.
      function void plot_current();
         plot_point_type p;
         p.right_x = OUT_BITS'(hold_cx + walk_x);
         p.left_x  = OUT_BITS'(hold_cx - walk_x);
         p.lower_y = OUT_BITS'(hold_cy + walk_y);
         p.upper_y = OUT_BITS'(hold_cy - walk_y);
         p.last    = (walk_y == 0);
         if (p.last) begin
            drawing = 1'b0;
         end
         expected_points.push_back(p);
      endfunction

      // Advance the walk for one accepted request beat.
      function void note_request(command_type cmd, bit [COORD_BITS-1:0] cx,
                                 bit [COORD_BITS-1:0] cy, bit [AXIS_BITS-1:0] a,
                                 bit [AXIS_BITS-1:0] b);
         bit [63:0] x;
         bit [63:0] y;
         bit [63:0] a_w;
         bit [63:0] b_w;
         bit        was_negative;
         requests_noted++;
         if (cmd == CMD_START) begin
            a_w         = a;
            b_w         = b;
            hold_cx     = cx;
            hold_cy     = cy;
            a_sq        = a_w * a_w;
            b_sq        = b_w * b_w;
            walk_x      = 0;
            walk_y      = b;
            decision    = 64'd4 * b_sq + a_sq - 64'd4 * a_sq * b_w;
            on_side_arc = 1'b0;
            drawing     = 1'b1;
            plot_current();
            return;
         end
         if (!drawing) begin
            return;
         end

         // Upper arc: x advances every step, y only when the decision allows.
         if (!on_side_arc) begin
            x = walk_x;
            y = walk_y;
            if (y != 0 && 64'd2 * b_sq * (x + 64'd1) < a_sq * (64'd2 * y - 64'd1)) begin
               was_negative = decision[63];
               decision += 64'd4 * b_sq * (64'd2 * x + 64'd3);
               if (!was_negative) begin
                  decision -= 64'd8 * a_sq * (y - 64'd1);
                  walk_y = 32'(y - 64'd1);
               end
               walk_x = 32'(x + 64'd1);
               plot_current();
               return;
            end
            // The arc test failed: reseed the decision for the side arc.
            decision = b_sq * (64'd2 * x + 64'd1) * (64'd2 * x + 64'd1)
                     + 64'd4 * a_sq * (y - 64'd1) * (y - 64'd1)
                     - 64'd4 * a_sq * b_sq;
            on_side_arc = 1'b1;
         end

         // Side arc: y drops every step, x only when the decision allows.
         x = walk_x;
         y = walk_y;
         if (y == 0) begin
            drawing = 1'b0;
            return;
         end
         if (decision[63]) begin
            decision += 64'd8 * b_sq * (x + 64'd1) + 64'd12 * a_sq - 64'd8 * a_sq * y;
            walk_x = 32'(x + 64'd1);
         end else begin
            decision += 64'd12 * a_sq - 64'd8 * a_sq * y;
         end
         walk_y = 32'(y - 64'd1);
         plot_current();
      endfunction

      // Compare a returned point with the oldest queued one.
      function void check_point(plot_point_type got);
         plot_point_type want;
         if (expected_points.size() == 0) begin
            flag_error($sformatf("unexpected point rx=%0d lx=%0d ly=%0d uy=%0d last=%0b",
                                 got.right_x, got.left_x, got.lower_y, got.upper_y,
                                 got.last));
            return;
         end
         want = expected_points.pop_front();
         if (got !== want) begin
            flag_error($sformatf({"point mismatch: expected rx=%0d lx=%0d ly=%0d uy=%0d ",
                                  "last=%0b, got rx=%0d lx=%0d ly=%0d uy=%0d last=%0b"},
                                 want.right_x, want.left_x, want.lower_y, want.upper_y,
                                 want.last, got.right_x, got.left_x, got.lower_y,
                                 got.upper_y, got.last));
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   phase_type         phase = PH_CORNER;
   int unsigned       cycle_count = 0;
   ellipse_scoreboard tracker = new();

   mer_req_if req_chan();
   mer_rsp_if rsp_chan();

   midpoint_ellipse_rasterizer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Feed every accepted request beat to the scoreboard.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         tracker.note_request(command_type'(req_chan.command), req_chan.center_x,
                              req_chan.center_y, req_chan.semi_a, req_chan.semi_b);
      end
   end

   // Check every accepted response beat.
   always @(posedge clock) begin : rsp_monitor
      plot_point_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.right_x = rsp_chan.right_x;
         got.left_x  = rsp_chan.left_x;
         got.lower_y = rsp_chan.lower_y;
         got.upper_y = rsp_chan.upper_y;
         got.last    = rsp_chan.last;
         tracker.check_point(got);
      end
   end

   // Response ready: random stalls, none in the steady phase, and one long
   // hold-off when the backlog phase begins.
   initial begin : rsp_ready_driver
      int unsigned hold_left;
      bit          held_once;
      hold_left = 0;
      held_once = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_BACKLOG && !held_once) begin
            held_once = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (phase == PH_STEADY || phase == PH_BACKLOG) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Offer one request beat and hold it until it is taken.
   task automatic send_beat(command_type cmd, logic [COORD_BITS-1:0] cx,
                            logic [COORD_BITS-1:0] cy, logic [AXIS_BITS-1:0] a,
                            logic [AXIS_BITS-1:0] b);
      if (phase == PH_CORNER || phase == PH_RANDOM) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.command  <= cmd;
      req_chan.center_x <= cx;
      req_chan.center_y <= cy;
      req_chan.semi_a   <= a;
      req_chan.semi_b   <= b;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // A step carries random geometry, which the block must ignore.
   task automatic send_step();
      send_beat(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                AXIS_BITS'($urandom), AXIS_BITS'($urandom));
   endtask

   task automatic draw_ellipse(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                               logic [AXIS_BITS-1:0] a, logic [AXIS_BITS-1:0] b,
                               int unsigned steps);
      send_beat(CMD_START, cx, cy, a, b);
      repeat (steps) send_step();
   endtask

   // One start followed by steps. Most ellipses are small and run to the end
   // with a few stray steps after it; some are cut short by the next start.
   task automatic random_ellipse();
      int unsigned pick;
      int unsigned a;
      int unsigned b;
      int unsigned steps;
      pick = $urandom_range(99);
      if (pick < 55) begin
         a     = $urandom_range(16);
         b     = $urandom_range(16);
         steps = a + b + $urandom_range(2);
      end else if (pick < 75) begin
         a     = $urandom_range(64);
         b     = $urandom_range(64);
         steps = a + b + $urandom_range(2);
      end else if (pick < 85) begin
         if ($urandom_range(1) == 1) begin
            a = 0;
            b = $urandom_range(20);
         end else begin
            a = $urandom_range(20);
            b = 0;
         end
         steps = a + b + $urandom_range(2);
      end else if (pick < 95) begin
         a     = $urandom_range(32);
         b     = $urandom_range(32);
         steps = $urandom_range(a + b);
      end else begin
         a     = $urandom_range(2047);
         b     = $urandom_range(2047);
         steps = $urandom_range(6);
      end
      draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom), AXIS_BITS'(a),
                   AXIS_BITS'(b), steps);
   endtask

   // Stimulus and end of test.
   initial begin
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.command  <= CMD_START;
      req_chan.center_x <= '0;
      req_chan.center_y <= '0;
      req_chan.semi_a   <= '0;
      req_chan.semi_b   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corner cases: a step with nothing in progress, both axes zero, a
      // vertical run at the top corner, a flat ellipse, an ellipse around
      // the origin that goes negative, and restarts of large ellipses.
      phase = PH_CORNER;
      send_step();
      draw_ellipse('0, '0, '0, '0, 1);
      draw_ellipse('1, '1, '0, 11'd3, 5);
      draw_ellipse(12'd100, 12'd200, 11'd5, '0, 1);
      draw_ellipse('0, '0, 11'd3, 11'd2, 5);
      draw_ellipse('1, '0, '1, '1, 3);
      draw_ellipse(12'd2048, 12'd2048, '1, 11'd1, 2);

      // Let the block drain completely before going on. The wait before the check
      // lets the last accepted beat reach the scoreboard first.
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_points.size() != 0) @(posedge clock);

      // No stalls on either side.
      phase = PH_STEADY;
      repeat (4) random_ellipse();

      // The response side holds off while requests keep coming.
      phase = PH_BACKLOG;
      draw_ellipse(12'd1000, 12'd1000, 11'd20, 11'd20, 40);

      phase = PH_RANDOM;
      while (tracker.requests_noted < ITEM_TARGET) random_ellipse();

      // Drain and let a trailing silent step finish.
      phase = PH_DRAIN;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_points.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.expected_points.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
